### rtl/rcnh_pkg.sv
// Shared types, codes and helpers for the nearest-hit ray collider.
`default_nettype none

package rcnh_pkg;

  // Input item: one collider, one inverse-rotation row, or a no-op code
  typedef struct packed {
    logic [1:0]          mode;
    logic [15:0]         entity_id;
    logic [1:0]          row_index;
    logic signed [31:0]  vec_x;
    logic signed [31:0]  vec_y;
    logic signed [31:0]  vec_z;
    logic [30:0]         ext_x;
    logic [30:0]         ext_y;
    logic [30:0]         ext_z;
    logic                last;
  } in_t;

  // Result item: nearest hit of one query
  typedef struct packed {
    logic                hit;
    logic [15:0]         hit_entity;
    logic [30:0]         hit_distance;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
  } out_t;

  // Item mode codes
  localparam logic [1:0] MODE_SPHERE = 2'd0;
  localparam logic [1:0] MODE_ROW    = 2'd1;
  localparam logic [1:0] MODE_BOX    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X    = 3'd3;
  localparam logic [2:0] CFG_DIR_Y    = 3'd4;
  localparam logic [2:0] CFG_DIR_Z    = 3'd5;

  localparam logic signed [17:0] DIR_Z_RESET = -18'sd65536;
  localparam logic [30:0]        DIST_MAX    = 31'h7fffffff;

  // Accumulator of the shared multiply-accumulate
  localparam int ACC_W = 67;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SQRT,
    ST_SROOT,
    ST_SLAB,
    ST_DIV,
    ST_DIVEND,
    ST_BOXEND,
    ST_CAND,
    ST_END
  } state_e;

  // Multiply-accumulate programs
  typedef enum logic [2:0] {
    MAC_DOT,   // oc . dir
    MAC_DISC,  // b^2 + r^2 - |oc|^2
    MAC_LO,    // row . rel, per-product floor shift
    MAC_LD,    // row . dir, per-product floor shift
    MAC_PT     // t * dir per axis, into the hit point
  } mac_e;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ray_collider_nearest_hit.sv
// Nearest-hit ray picker over sphere and oriented-box colliders, iterative datapath.
//
//  channel | signals                          | direction | transfer when
//  in      | in_valid_i, in_stall_o, in_data_i | to block  | valid high, stall low
//  out     | out_valid_o, out_stall_i, out_data_o | from block | valid high, stall low
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i  | to block  | write enable high
//
// One item at a time through one 32x32 multiplier, a one-bit-per-cycle square root
// and a one-bit-per-cycle divider. in_stall_o is high while an item is in work.
// Reset is asynchronous; the inverse-rotation rows are not cleared by it.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module ray_collider_nearest_hit #(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [2:0]            cfg_idx_i,
  input  wire [31:0]           cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  rcnh_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output rcnh_pkg::out_t       out_data_o
);
  import rcnh_pkg::*;

  localparam int NW     = 32 + FRAC_BITS;      // divider numerator bits
  localparam int TW     = NW + 2;              // slab time width
  localparam int CNT_W  = $clog2(NW);
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int EPS    = (EPS_RAW < 1) ? 1 : EPS_RAW;
  localparam logic signed [TW-1:0] BIG = TW'(64'sd100000 <<< FRAC_BITS);

  // Configuration registers
  logic signed [31:0] origin_q [3];
  logic signed [17:0] dir_q [3];

  // Control
  state_e             state_q, state_d;
  mac_e               kind_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         row_i_q;
  logic               div_ph_q;

  // Item and working values
  in_t                item_q;
  logic signed [31:0] rel_q [3];
  logic signed [31:0] rows_q [3][3];
  logic signed [63:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] b_q, lo_q, ld_q;
  logic [63:0]        sq_x_q, sq_r_q, sq_bit_q;
  logic [NW-1:0]      div_num_q;
  logic [31:0]        div_rem_q;
  logic [31:0]        div_den_q;
  logic               div_neg_q;
  logic signed [TW-1:0] t1_q, tn_q, tf_q;
  logic [30:0]        t31_q;

  // Nearest hit
  logic               best_valid_q;
  logic [30:0]        best_dist_q;
  logic [15:0]        best_ent_q;
  logic signed [31:0] best_pt_q [3];

  logic               out_valid_q;
  out_t               out_q;

  function automatic logic signed [31:0] pick3(input logic signed [31:0] a0,
                                               input logic signed [31:0] a1,
                                               input logic signed [31:0] a2,
                                               input logic [1:0] s);
    logic signed [31:0] r;
    case (s)
      2'd1:    r = a1;
      2'd2:    r = a2;
      default: r = a0;
    endcase
    return r;
  endfunction

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // ---------------- shared multiplier operands ----------------
  logic [1:0]         j_idx, p_idx;
  logic signed [31:0] row_sel [3];
  logic signed [31:0] mul_a, mul_b;
  logic [CNT_W-1:0]   mac_n;
  logic               mac_done;

  assign p_idx = 2'(cnt_q - CNT_W'(1));

  always_comb begin
    if (row_i_q == 2'd1) begin
      row_sel = rows_q[1];
    end else if (row_i_q == 2'd2) begin
      row_sel = rows_q[2];
    end else begin
      row_sel = rows_q[0];
    end
  end

  always_comb begin
    j_idx = (kind_q == MAC_DISC) ? 2'(cnt_q - CNT_W'(2)) : cnt_q[1:0];
    mul_a = '0;
    mul_b = '0;
    unique case (kind_q)
      MAC_DOT: begin
        mul_a = pick3(rel_q[0], rel_q[1], rel_q[2], j_idx);
        mul_b = pick3(32'(dir_q[0]), 32'(dir_q[1]), 32'(dir_q[2]), j_idx);
      end
      MAC_DISC: begin
        if (cnt_q == CNT_W'(0)) begin
          mul_a = b_q;
          mul_b = b_q;
        end else if (cnt_q == CNT_W'(1)) begin
          mul_a = $signed({1'b0, item_q.ext_x});
          mul_b = $signed({1'b0, item_q.ext_x});
        end else begin
          mul_a = pick3(rel_q[0], rel_q[1], rel_q[2], j_idx);
          mul_b = pick3(rel_q[0], rel_q[1], rel_q[2], j_idx);
        end
      end
      MAC_LO: begin
        mul_a = pick3(row_sel[0], row_sel[1], row_sel[2], j_idx);
        mul_b = pick3(rel_q[0], rel_q[1], rel_q[2], j_idx);
      end
      MAC_LD: begin
        mul_a = pick3(row_sel[0], row_sel[1], row_sel[2], j_idx);
        mul_b = pick3(32'(dir_q[0]), 32'(dir_q[1]), 32'(dir_q[2]), j_idx);
      end
      MAC_PT: begin
        mul_a = $signed({1'b0, t31_q});
        mul_b = pick3(32'(dir_q[0]), 32'(dir_q[1]), 32'(dir_q[2]), j_idx);
      end
    endcase
  end

  assign mac_n    = (kind_q == MAC_DISC) ? CNT_W'(5) : CNT_W'(3);
  assign mac_done = (cnt_q == mac_n);

  // Accumulate the product registered in the previous cycle
  logic signed [ACC_W-1:0] term, acc_nx;
  logic                    term_neg;
  logic signed [31:0]      pt_val;

  always_comb begin
    if (kind_q == MAC_LO || kind_q == MAC_LD) begin
      term = ACC_W'(prod_q >>> FRAC_BITS);
    end else begin
      term = ACC_W'(prod_q);
    end
    term_neg = (kind_q == MAC_DISC) && (cnt_q >= CNT_W'(3));
    acc_nx   = term_neg ? (acc_q - term) : (acc_q + term);
    pt_val   = sat32(72'(pick3(origin_q[0], origin_q[1], origin_q[2], p_idx))
                     + 72'(prod_q >>> FRAC_BITS));
  end

  // ---------------- square root step ----------------
  logic [63:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = sq_r_q + sq_bit_q;
  assign sq_ge  = (sq_x_q >= sq_sum);

  // Sphere root choice
  logic signed [34:0] nb, ta, tb, tsel;
  logic               sph_miss;
  logic [30:0]        sph_t31;
  always_comb begin
    nb       = -(35'(b_q));
    ta       = nb - $signed({3'b000, sq_r_q[31:0]});
    tb       = nb + $signed({3'b000, sq_r_q[31:0]});
    tsel     = (ta < 35'(EPS)) ? tb : ta;
    sph_miss = (tsel < 35'(EPS));
    sph_t31  = (tsel > 35'sd2147483647) ? DIST_MAX : tsel[30:0];
  end

  // ---------------- slab test ----------------
  logic [30:0]        ext_cur;
  logic signed [32:0] ext33, lo33, ld_abs;
  logic               flat, lo_out;
  logic signed [33:0] numer;
  logic [31:0]        numer_mag;
  always_comb begin
    unique case (row_i_q)
      2'd1:    ext_cur = item_q.ext_y;
      2'd2:    ext_cur = item_q.ext_z;
      default: ext_cur = item_q.ext_x;
    endcase
    ext33  = $signed({2'b00, ext_cur});
    lo33   = 33'(lo_q);
    ld_abs = (ld_q < 0) ? -(33'(ld_q)) : 33'(ld_q);
    flat   = (ld_abs < 33'(EPS));
    lo_out = (lo33 < -ext33) || (lo33 > ext33);
    numer  = (state_q == ST_SLAB) ? (-(34'(ext33)) - 34'(lo33))
                                  : (34'(ext33) - 34'(lo33));
    numer_mag = (numer < 0) ? 32'(-numer) : 32'(numer);
  end

  // Divider step, one quotient bit per cycle
  logic [32:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem_q, div_num_q[NW-1]};
  assign div_ge = (div_sh >= {1'b0, div_den_q});

  logic signed [TW-1:0] quo, lo_t, hi_t, tn_new, tf_new, tpos;
  logic                 slab_empty;
  logic [30:0]          box_t31;
  always_comb begin
    quo        = div_neg_q ? -(TW'({2'b00, div_num_q})) : TW'({2'b00, div_num_q});
    lo_t       = (t1_q > quo) ? quo : t1_q;
    hi_t       = (t1_q > quo) ? t1_q : quo;
    tn_new     = (lo_t > tn_q) ? lo_t : tn_q;
    tf_new     = (hi_t < tf_q) ? hi_t : tf_q;
    slab_empty = (tn_new > tf_new);
    tpos       = (tn_q < 0) ? '0 : tn_q;
    box_t31    = (tpos > TW'(64'sd2147483647)) ? DIST_MAX : tpos[30:0];
  end

  logic take, row_next, div_load, out_free;
  assign take     = !best_valid_q || (t31_q < best_dist_q);
  assign row_next = ((state_q == ST_SLAB) && flat && !lo_out)
                 || ((state_q == ST_DIVEND) && div_ph_q && !slab_empty);
  assign div_load = ((state_q == ST_SLAB) && !flat)
                 || ((state_q == ST_DIVEND) && !div_ph_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.mode == MODE_SPHERE || in_data_i.mode == MODE_BOX) begin
            state_d = ST_MAC;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          unique case (kind_q)
            MAC_DOT, MAC_LO: state_d = ST_MAC;
            MAC_DISC:        state_d = (acc_nx < 0) ? ST_END : ST_SQRT;
            MAC_LD:          state_d = ST_SLAB;
            MAC_PT:          state_d = ST_END;
          endcase
        end
      end
      ST_SQRT: begin
        if (cnt_q == CNT_W'(31)) begin
          state_d = ST_SROOT;
        end
      end
      ST_SROOT:  state_d = sph_miss ? ST_END : ST_CAND;
      ST_SLAB: begin
        if (!flat) begin
          state_d = ST_DIV;
        end else if (lo_out) begin
          state_d = ST_END;
        end else begin
          state_d = (row_i_q == 2'd2) ? ST_BOXEND : ST_MAC;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(NW - 1)) begin
          state_d = ST_DIVEND;
        end
      end
      ST_DIVEND: begin
        if (!div_ph_q) begin
          state_d = ST_DIV;
        end else if (slab_empty) begin
          state_d = ST_END;
        end else begin
          state_d = (row_i_q == 2'd2) ? ST_BOXEND : ST_MAC;
        end
      end
      ST_BOXEND: state_d = (tf_q < 0) ? ST_END : ST_CAND;
      ST_CAND:   state_d = take ? ST_MAC : ST_END;
      ST_END: begin
        if (!item_q.last || out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // ---------------- registers with reset ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= MAC_DOT;
      cnt_q        <= '0;
      row_i_q      <= '0;
      div_ph_q     <= 1'b0;
      origin_q     <= '{default: '0};
      dir_q[0]     <= '0;
      dir_q[1]     <= '0;
      dir_q[2]     <= DIR_Z_RESET;
      best_valid_q <= 1'b0;
      best_dist_q  <= DIST_MAX;
      best_ent_q   <= '0;
      best_pt_q    <= '{default: '0};
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X: origin_q[0] <= $signed(cfg_wdata_i);
          CFG_ORIGIN_Y: origin_q[1] <= $signed(cfg_wdata_i);
          CFG_ORIGIN_Z: origin_q[2] <= $signed(cfg_wdata_i);
          CFG_DIR_X:    dir_q[0]    <= $signed(cfg_wdata_i[17:0]);
          CFG_DIR_Y:    dir_q[1]    <= $signed(cfg_wdata_i[17:0]);
          CFG_DIR_Z:    dir_q[2]    <= $signed(cfg_wdata_i[17:0]);
          default: ;
        endcase
      end

      // output transfer
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q   <= '0;
            row_i_q <= '0;
            kind_q  <= (in_data_i.mode == MODE_BOX) ? MAC_LO : MAC_DOT;
          end
        end
        ST_MAC: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (kind_q == MAC_PT && cnt_q != '0) begin
            best_pt_q[p_idx] <= pt_val;
          end
          if (mac_done) begin
            cnt_q <= '0;
            unique case (kind_q)
              MAC_DOT:  kind_q <= MAC_DISC;
              MAC_LO:   kind_q <= MAC_LD;
              MAC_PT: begin
                best_valid_q <= 1'b1;
                best_dist_q  <= t31_q;
                best_ent_q   <= item_q.entity_id;
              end
              MAC_DISC, MAC_LD: ;
            endcase
          end
        end
        ST_SQRT, ST_DIV: begin
          cnt_q <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
        end
        ST_CAND: begin
          if (take) begin
            kind_q <= MAC_PT;
            cnt_q  <= '0;
          end
        end
        ST_END: begin
          if (item_q.last && out_free) begin
            out_valid_q             <= 1'b1;
            out_q.hit               <= best_valid_q;
            out_q.hit_entity        <= best_valid_q ? best_ent_q : '0;
            out_q.hit_distance      <= best_valid_q ? best_dist_q : '0;
            out_q.point_x           <= best_valid_q ? best_pt_q[0] : '0;
            out_q.point_y           <= best_valid_q ? best_pt_q[1] : '0;
            out_q.point_z           <= best_valid_q ? best_pt_q[2] : '0;
            best_valid_q            <= 1'b0;
            best_dist_q             <= DIST_MAX;
            best_ent_q              <= '0;
            best_pt_q               <= '{default: '0};
          end
        end
        ST_SROOT, ST_SLAB, ST_DIVEND, ST_BOXEND: ;
      endcase

      // next box row
      if (row_next && row_i_q != 2'd2) begin
        row_i_q <= row_i_q + 2'd1;
        kind_q  <= MAC_LO;
        cnt_q   <= '0;
      end

      // divider setup
      if (div_load) begin
        cnt_q    <= '0;
        div_ph_q <= (state_q == ST_DIVEND);
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_q   <= in_data_i;
          rel_q[0] <= sat32(72'(origin_q[0]) - 72'(in_data_i.vec_x));
          rel_q[1] <= sat32(72'(origin_q[1]) - 72'(in_data_i.vec_y));
          rel_q[2] <= sat32(72'(origin_q[2]) - 72'(in_data_i.vec_z));
          acc_q    <= '0;
          tn_q     <= -BIG;
          tf_q     <= BIG;
          if (in_data_i.mode == MODE_ROW && in_data_i.row_index != 2'd3) begin
            rows_q[in_data_i.row_index][0] <= in_data_i.vec_x;
            rows_q[in_data_i.row_index][1] <= in_data_i.vec_y;
            rows_q[in_data_i.row_index][2] <= in_data_i.vec_z;
          end
        end
      end
      ST_MAC: begin
        if (cnt_q != '0) begin
          acc_q <= acc_nx;
        end
        if (mac_done) begin
          acc_q <= '0;
          unique case (kind_q)
            MAC_DOT: b_q  <= sat32(72'(acc_nx >>> FRAC_BITS));
            MAC_LO:  lo_q <= sat32(72'(acc_nx));
            MAC_LD:  ld_q <= sat32(72'(acc_nx));
            MAC_DISC: begin
              sq_x_q   <= acc_nx[63:0];
              sq_r_q   <= '0;
              sq_bit_q <= 64'd1 << 62;
            end
            MAC_PT: ;
          endcase
        end
      end
      ST_SQRT: begin
        sq_x_q   <= sq_ge ? (sq_x_q - sq_sum) : sq_x_q;
        sq_r_q   <= sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);
        sq_bit_q <= sq_bit_q >> 2;
      end
      ST_SROOT:  t31_q <= sph_t31;
      ST_DIV: begin
        div_rem_q <= div_ge ? 32'(div_sh - {1'b0, div_den_q}) : div_sh[31:0];
        div_num_q <= {div_num_q[NW-2:0], div_ge};
      end
      ST_DIVEND: begin
        if (!div_ph_q) begin
          t1_q <= quo;
        end else begin
          tn_q <= tn_new;
          tf_q <= tf_new;
        end
      end
      ST_BOXEND: t31_q <= box_t31;
      ST_SLAB, ST_CAND, ST_END: ;
    endcase

    if (row_next) begin
      acc_q <= '0;
    end

    // divider load: magnitude shifted up by the fraction bits
    if (div_load) begin
      div_num_q <= {numer_mag, {FRAC_BITS{1'b0}}};
      div_rem_q <= '0;
      div_den_q <= ld_abs[31:0];
      div_neg_q <= (numer < 0) ^ (ld_q < 0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_out_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_END && item_q.last))
    else $error("result raised without a last item");

  a_clear_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !best_valid_q |-> (best_dist_q == DIST_MAX))
    else $error("nearest distance not cleared while no hit is held");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_acc) |=> in_stall_o)
    else $error("accepted item did not stall the input");

endmodule

`default_nettype wire
